>>> rtl/pcxrle_pkg.sv
// Shared types and constants of the PCX run-length line encoder.
// Holds the run and queue entry formats and the count byte helpers.
// No dependencies.
package pcxrle_pkg;

	localparam int BYTE_W = 8;
	localparam int RUN_W = 6;
	localparam logic [BYTE_W-1:0] COUNT_MARK = 8'hC0;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic [RUN_W-1:0] length;
	} run_t;

	typedef struct packed {
		logic a_valid;
		run_t a;
		logic b_valid;
		run_t b;
	} cmd_t;

	typedef struct packed {
		logic b_value;
		logic b_count;
		logic a_value;
		logic a_count;
	} slots_t;

	function automatic logic needs_count(input run_t r);
		return (r.length > RUN_W'(1)) || (r.value[BYTE_W-1:BYTE_W-2] == 2'b11);
	endfunction

	function automatic logic [BYTE_W-1:0] count_byte(input run_t r);
		return COUNT_MARK | BYTE_W'(r.length);
	endfunction

	function automatic slots_t entry_slots(input cmd_t c);
		slots_t s;
		s.a_count = c.a_valid & needs_count(c.a);
		s.a_value = c.a_valid;
		s.b_count = c.b_valid & needs_count(c.b);
		s.b_value = c.b_valid;
		return s;
	endfunction

endpackage

>>> rtl/pcxrle_front.sv
// Front end: accepts pixels, tracks the open run and the column, and
// classifies each pixel into zero, one or two closed runs for the queue.
// Depends on pcxrle_pkg.
module pcxrle_front import pcxrle_pkg::*; #(
	parameter int MAX_LINE_WIDTH = 4096,
	parameter int MAX_RUN = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [12:0] line_width,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  pixel,
	input  logic        q_full,
	output logic        q_push,
	output cmd_t        q_wdata
);

	localparam int COL_W = $clog2(MAX_LINE_WIDTH + 1);
	localparam int RESET_WIDTH = (640 > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : 640;

	logic [COL_W-1:0]  width_q;
	logic [COL_W-1:0]  column_q;
	logic [BYTE_W-1:0] run_value_q;
	logic [RUN_W-1:0]  run_length_q;

	logic [31:0]       width_ext;
	logic [31:0]       width_sel;
	logic              accept;
	logic              differ;
	logic [BYTE_W-1:0] val_join;
	logic [RUN_W-1:0]  len_join;
	logic [COL_W-1:0]  col_inc;
	logic              line_end;
	logic              close_b;

	always_comb begin
		width_ext = 32'(line_width);
		if (width_ext == 32'd0) begin
			width_sel = 32'd1;
		end else if (width_ext > 32'(MAX_LINE_WIDTH)) begin
			width_sel = 32'(MAX_LINE_WIDTH);
		end else begin
			width_sel = width_ext;
		end
	end

	always_comb begin
		accept = in_valid && !q_full;
		differ = (run_length_q != '0) && (pixel != run_value_q);
		if ((run_length_q == '0) || differ) begin
			val_join = pixel;
			len_join = RUN_W'(1);
		end else begin
			val_join = run_value_q;
			len_join = RUN_W'(run_length_q + 1'b1);
		end
		col_inc = COL_W'(column_q + 1'b1);
		line_end = col_inc >= width_q;
		close_b = (len_join >= RUN_W'(MAX_RUN)) || line_end;

		q_wdata.a_valid = differ;
		q_wdata.a.value = run_value_q;
		q_wdata.a.length = run_length_q;
		q_wdata.b_valid = close_b;
		q_wdata.b.value = val_join;
		q_wdata.b.length = len_join;

		q_push = accept && (differ || close_b);
		in_stall = q_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= COL_W'(RESET_WIDTH);
		end else if (cfg_wr_en) begin
			width_q <= COL_W'(width_sel);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			run_value_q <= '0;
			run_length_q <= '0;
		end else if (accept) begin
			column_q <= line_end ? '0 : col_inc;
			run_value_q <= val_join;
			run_length_q <= close_b ? '0 : len_join;
		end
	end

endmodule

>>> rtl/pcxrle_queue.sv
// Short queue of closed-run commands between front and back ends.
// Register-file storage with head read; depends on pcxrle_pkg.
module pcxrle_queue import pcxrle_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= QCNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= QCNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

>>> rtl/pcxrle_back.sv
// Back end: expands each queued command into count and value bytes,
// one byte per cycle while out_stall is low, through a registered output. Depends on pcxrle_pkg.
module pcxrle_back import pcxrle_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  cmd_t              q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] out_byte,
	output logic              last
);

	cmd_t              cur_q;
	slots_t            mask_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_q;

	cmd_t              src;
	slots_t            src_mask;
	slots_t            rest;
	logic [BYTE_W-1:0] next_byte;
	logic              load;

	always_comb begin
		if (mask_q != '0) begin
			src = cur_q;
			src_mask = mask_q;
		end else begin
			src = q_head;
			src_mask = q_empty ? '0 : entry_slots(q_head);
		end

		rest = src_mask;
		next_byte = src.b.value;
		priority if (src_mask.a_count) begin
			next_byte = count_byte(src.a);
			rest.a_count = 1'b0;
		end else if (src_mask.a_value) begin
			next_byte = src.a.value;
			rest.a_value = 1'b0;
		end else if (src_mask.b_count) begin
			next_byte = count_byte(src.b);
			rest.b_count = 1'b0;
		end else begin
			next_byte = src.b.value;
			rest.b_value = 1'b0;
		end

		load = !out_valid_q || !out_stall;
		q_pop = load && (mask_q == '0) && !q_empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			mask_q <= '0;
		end else if (load) begin
			out_valid_q <= src_mask != '0;
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= src;
			out_byte_q <= next_byte;
			last_q <= rest == '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign last = last_q;

endmodule

>>> rtl/pcx_rle_line_encoder.sv
// PCX run-length line encoder, top level.
// Path: a pixel's runs are written into the queue storage and then loaded into the
// output register, where their first byte becomes valid behind any older bytes.
// Throughput: one pixel per cycle while the four-entry command queue has room;
// the output port sends one byte per cycle while out_stall is low, and a pixel yields 0 to 4 bytes.
// Reset: no open run, column zero, line width 640 (limited to MAX_LINE_WIDTH).
module pcx_rle_line_encoder import pcxrle_pkg::*; #(
	parameter int MAX_LINE_WIDTH = 4096,
	parameter int MAX_RUN = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [12:0] line_width,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  pixel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last
);

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	cmd_t q_wdata;
	cmd_t q_head;

	pcxrle_front #(
		.MAX_LINE_WIDTH(MAX_LINE_WIDTH),
		.MAX_RUN(MAX_RUN)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.line_width(line_width),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel(pixel),
		.q_full(q_full),
		.q_push(q_push),
		.q_wdata(q_wdata)
	);

	pcxrle_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.full(q_full),
		.pop(q_pop),
		.head(q_head),
		.empty(q_empty)
	);

	pcxrle_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_head(q_head),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last(last)
	);

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue push while full");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue pop while empty");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && !q_pop |=> !q_empty)
		else $error("queue empty after push");

endmodule
